@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same but checked during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ src/kmcl_pkg.sv @@
// package with types and constants of the keypad code lock
`default_nettype none
package kmcl_pkg;
  localparam int unsigned ChannelsDefault   = 15;
  localparam int unsigned CodeDigitsDefault = 6;
  localparam int unsigned StoreDepth        = 16;

  localparam logic [4:0] KeyClear = 5'd13;
  localparam logic [4:0] KeyEnter = 5'd15;
  localparam logic [4:0] KeyMax   = 5'd16;
  localparam logic [3:0] NoDigit  = 4'hf;

  typedef enum logic [2:0] {
    MODE_SET_COUNT = 3'd0,
    MODE_SET_ADMIN = 3'd1,
    MODE_NORMAL    = 3'd2,
    MODE_ADMIN_CHK = 3'd3,
    MODE_PROG_ALL  = 3'd4,
    MODE_SELECT    = 3'd5,
    MODE_EDIT      = 3'd6
  } lock_mode_e;

  typedef enum logic [3:0] {
    ST_TYPING     = 4'd0,
    ST_OPENED     = 4'd1,
    ST_WRONG      = 4'd2,
    ST_ADMIN_OK   = 4'd3,
    ST_ADMIN_BAD  = 4'd4,
    ST_COUNT_OK   = 4'd5,
    ST_COUNT_BAD  = 4'd6,
    ST_CODE_SAVED = 4'd7,
    ST_NO_CHANNEL = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_SCAN,
    FSM_FINISH,
    FSM_ERASE,
    FSM_OUT
  } fsm_e;

  // datapath actions
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECODE,
    OP_SCAN,
    OP_FINISH,
    OP_ERASE_STEP,
    OP_ERASE_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_erase;
    logic is_enter;
    logic need_scan;
    logic scan_last;
    logic erase_last;
  } dp_stat_t;

  function automatic logic [3:0] key_digit(input logic [4:0] key);
    logic [3:0] d;
    begin
      unique case (key)
        5'd1: d = 4'd1;
        5'd2: d = 4'd2;
        5'd3: d = 4'd3;
        5'd5: d = 4'd4;
        5'd6: d = 4'd5;
        5'd7: d = 4'd6;
        5'd9: d = 4'd7;
        5'd10: d = 4'd8;
        5'd11: d = 4'd9;
        5'd14: d = 4'd0;
        default: d = NoDigit;
      endcase
      return d;
    end
  endfunction
endpackage
`default_nettype wire

@@ src/kmcl_ctrl.sv @@
// controller state machine of the keypad code lock
`default_nettype none
module kmcl_ctrl
  import kmcl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);
  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = FSM_DECODE;
        end
      end
      FSM_DECODE: begin
        if (stat_i.is_erase) begin
          state_d = FSM_ERASE;
        end else if (stat_i.need_scan) begin
          cmd_o.op = OP_DECODE;
          state_d  = FSM_SCAN;
        end else begin
          cmd_o.op = OP_DECODE;
          state_d  = FSM_OUT;
        end
      end
      FSM_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (stat_i.scan_last) state_d = FSM_FINISH;
      end
      FSM_FINISH: begin
        cmd_o.op = OP_FINISH;
        state_d  = FSM_OUT;
      end
      FSM_ERASE: begin
        // one store entry a cycle
        cmd_o.op = OP_ERASE_STEP;
        if (stat_i.erase_last) begin
          cmd_o.op = OP_ERASE_DONE;
          state_d  = FSM_OUT;
        end
      end
      FSM_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ src/kmcl_datapath.sv @@
// datapath of the keypad code lock: code store, buffers and compare
`default_nettype none
module kmcl_datapath
  import kmcl_pkg::*;
#(
  parameter int unsigned CHANNELS    = ChannelsDefault,
  parameter int unsigned CODE_DIGITS = CodeDigitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dp_cmd_t       cmd_i,
  output dp_stat_t           stat_o,
  input  wire logic          kind_i,
  input  wire logic [4:0]    key_code_i,
  output logic [3:0]         status_o,
  output logic [CHANNELS-1:0] open_mask_o,
  output logic [2:0]         mode_o,
  output logic [2:0]         stars_shown_o,
  output logic [3:0]         channel_o
);
  localparam int unsigned CW = 4 * CODE_DIGITS;
  localparam int unsigned StarCap = (CODE_DIGITS < 7) ? CODE_DIGITS : 7;
  localparam logic [CW-1:0] AllNines = {CODE_DIGITS{4'h9}};
  localparam logic [CW-1:0] Magic1 = AllNines;
  localparam logic [CW-1:0] Magic2 = {AllNines[CW-1:4], 4'h1};
  localparam logic [CW-1:0] Magic3 = {AllNines[CW-1:4], 4'h2};
  localparam logic [4:0] ChanLim = 5'(CHANNELS);
  localparam logic [6:0] ChanVal = 7'(CHANNELS);

  logic [CW-1:0] store_q [StoreDepth];
  logic [CW-1:0] entry_q, entry_d;
  logic [7:0]    chd_q, chd_d;
  logic [4:0]    count_q, count_d;
  lock_mode_e    mode_q, mode_d;
  logic [1:0]    path_q, path_d;
  logic [3:0]    cur_q, cur_d;
  logic [2:0]    star_q, star_d;
  logic          kind_q;
  logic [4:0]    key_q;
  logic [3:0]    status_q, status_d;
  logic [CHANNELS-1:0] mask_q, mask_d;
  logic [3:0]    idx_q, idx_d;
  logic          wr_en;
  logic [3:0]    wr_addr;
  logic [CW-1:0] wr_data;
  logic [3:0]    lim;
  logic [6:0]    chv;
  logic          is_enter;
  logic [3:0]    dig;

  assign lim      = (count_q > ChanLim) ? ChanLim[3:0] : count_q[3:0];
  assign chv      = 7'(chd_q[7:4]) * 7'd10 + 7'(chd_q[3:0]);
  assign is_enter = !kind_q && key_q == KeyEnter;
  assign dig      = key_digit(key_q);

  assign stat_o.is_erase   = kind_q;
  assign stat_o.is_enter   = is_enter;
  assign stat_o.need_scan  = is_enter && mode_q == MODE_NORMAL &&
                             entry_q != Magic1 && entry_q != Magic2 && entry_q != Magic3;
  assign stat_o.scan_last  = idx_q >= lim;
  assign stat_o.erase_last = idx_q == 4'(StoreDepth - 1);

  always_comb begin
    entry_d  = entry_q;
    chd_d    = chd_q;
    count_d  = count_q;
    mode_d   = mode_q;
    path_d   = path_q;
    cur_d    = cur_q;
    star_d   = star_q;
    status_d = status_q;
    mask_d   = mask_q;
    idx_d    = idx_q;
    wr_en    = 1'b0;
    wr_addr  = cur_q;
    wr_data  = entry_q;
    case (cmd_i.op)
      OP_LOAD: begin
        status_d = ST_TYPING;
        mask_d   = '0;
        idx_d    = '0;
      end
      OP_DECODE: begin
        if (key_q > KeyMax) begin
          // ignored key
        end else if (key_q == KeyClear) begin
          entry_d = '0; chd_d = '0; star_d = '0;
        end else if (is_enter) begin
          unique case (mode_q)
            MODE_SET_COUNT: begin
              if (chv <= ChanVal) begin
                count_d = chv[4:0]; mode_d = MODE_SET_ADMIN;
                entry_d = '0; chd_d = '0; star_d = '0;
                status_d = ST_COUNT_OK;
              end else begin
                chd_d = '0; status_d = ST_COUNT_BAD;
              end
            end
            MODE_SET_ADMIN: begin
              wr_en = 1'b1; wr_addr = '0;
              mode_d = MODE_NORMAL;
              entry_d = '0; chd_d = '0; star_d = '0;
              status_d = ST_CODE_SAVED;
            end
            MODE_NORMAL: begin
              // magic codes only; other entries go through the scan
              path_d = (entry_q == Magic1) ? 2'd1 : (entry_q == Magic2) ? 2'd2 : 2'd3;
              mode_d = MODE_ADMIN_CHK;
              entry_d = '0; chd_d = '0; star_d = '0;
              idx_d = 4'd1;
            end
            MODE_ADMIN_CHK: begin
              entry_d = '0; chd_d = '0; star_d = '0;
              if (entry_q != store_q[0]) begin
                mode_d = MODE_NORMAL; status_d = ST_ADMIN_BAD;
              end else begin
                status_d = ST_ADMIN_OK;
                case (path_q)
                  2'd1: begin
                    cur_d = 4'd1;
                    mode_d = (lim == '0) ? MODE_NORMAL : MODE_PROG_ALL;
                  end
                  2'd2: mode_d = MODE_SELECT;
                  2'd3: mode_d = MODE_SET_ADMIN;
                  default: mode_d = MODE_NORMAL;
                endcase
              end
            end
            MODE_PROG_ALL: begin
              entry_d = '0; chd_d = '0; star_d = '0;
              if (cur_q < 4'd1 || cur_q > lim) begin
                mode_d = MODE_NORMAL;
              end else begin
                wr_en = 1'b1;
                status_d = ST_CODE_SAVED;
                if (cur_q >= lim) mode_d = MODE_NORMAL;
                else cur_d = cur_q + 4'd1;
              end
            end
            MODE_SELECT: begin
              if (chv != '0 && chv <= {3'b0, lim}) begin
                cur_d = chv[3:0]; mode_d = MODE_EDIT;
                entry_d = '0; chd_d = '0; star_d = '0;
              end else begin
                chd_d = '0; status_d = ST_NO_CHANNEL;
              end
            end
            MODE_EDIT: begin
              wr_en = 1'b1;
              mode_d = MODE_NORMAL;
              entry_d = '0; chd_d = '0; star_d = '0;
              status_d = ST_CODE_SAVED;
            end
            default: begin
              mode_d = MODE_NORMAL;
              entry_d = '0; chd_d = '0; star_d = '0;
            end
          endcase
        end else if (dig != NoDigit) begin
          if (mode_q == MODE_SET_COUNT || mode_q == MODE_SELECT) begin
            chd_d = {chd_q[3:0], dig};
          end else begin
            entry_d = {entry_q[CW-5:0], dig};
            if (star_q < 3'(StarCap)) star_d = star_q + 3'd1;
          end
        end
        // normal-mode compare starts at the admin entry
        if (stat_o.need_scan) begin
          mode_d = mode_q; path_d = path_q; entry_d = entry_q;
          chd_d = chd_q; star_d = star_q;
          idx_d = 4'd0;
        end
      end
      OP_SCAN: begin
        if (idx_q == '0) begin
          if (entry_q == store_q[0]) mask_d = '1;
        end else if (idx_q <= lim && entry_q == store_q[idx_q]) begin
          mask_d = mask_q | (CHANNELS'(1) << (idx_q - 4'd1));
        end
        idx_d = idx_q + 4'd1;
      end
      OP_FINISH: begin
        status_d = (mask_q != '0) ? ST_OPENED : ST_WRONG;
        mode_d = MODE_NORMAL;
        entry_d = '0; chd_d = '0; star_d = '0;
      end
      OP_ERASE_STEP, OP_ERASE_DONE: begin
        wr_en = 1'b1; wr_addr = idx_q; wr_data = '1;
        idx_d = idx_q + 4'd1;
        if (cmd_i.op == OP_ERASE_DONE) begin
          count_d = '1; path_d = '0; cur_d = '0;
          mode_d = MODE_SET_COUNT;
          entry_d = '0; chd_d = '0; star_d = '0;
          status_d = ST_TYPING; mask_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      kind_q <= kind_i;
      key_q  <= key_code_i;
    end
    status_q <= status_d;
    mask_q   <= mask_d;
    idx_q    <= idx_d;
  end

  // store entries come out of reset unprogrammed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) store_q[i] <= '1;
    end else begin
      if (wr_en) store_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      chd_q   <= '0;
      count_q <= '1;
      mode_q  <= MODE_SET_COUNT;
      path_q  <= '0;
      cur_q   <= '0;
      star_q  <= '0;
    end else begin
      entry_q <= entry_d;
      chd_q   <= chd_d;
      count_q <= count_d;
      mode_q  <= mode_d;
      path_q  <= path_d;
      cur_q   <= cur_d;
      star_q  <= star_d;
    end
  end

  assign status_o      = status_q;
  assign open_mask_o   = (status_q == ST_OPENED) ? mask_q : '0;
  assign mode_o        = mode_q;
  assign stars_shown_o = (mode_q == MODE_SET_COUNT || mode_q == MODE_SELECT) ? 3'd0 : star_q;
  assign channel_o     = cur_q;
endmodule
`default_nettype wire

@@ src/keypad_multichannel_code_lock_unit.sv @@
// Top level of the multichannel keypad code lock.
// A plain key is loaded, decoded and shown; a normal-mode Enter that is no
// magic code also scans the set channel count + 1 store entries (up to 16),
// and a factory erase writes all 16 entries. One word at a time: the next is
// taken in the cycle after the result leaves.
// Reset: async, active low; the store resets to unprogrammed entries.
`default_nettype none
module keypad_multichannel_code_lock_unit
  import kmcl_pkg::*;
#(
  parameter int unsigned CHANNELS    = ChannelsDefault,
  parameter int unsigned CODE_DIGITS = CodeDigitsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             kind_i,
  input  wire logic [4:0]       key_code_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [3:0]            status_o,
  output logic [CHANNELS-1:0]   open_mask_o,
  output logic [2:0]            mode_o,
  output logic [2:0]            stars_shown_o,
  output logic [3:0]            channel_o
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  kmcl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  kmcl_datapath #(.CHANNELS(CHANNELS), .CODE_DIGITS(CODE_DIGITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .kind_i, .key_code_i,
    .status_o, .open_mask_o, .mode_o, .stars_shown_o, .channel_o
  );
endmodule
`default_nettype wire

@@ src/kmcl_checker.sv @@
// port-level checker of the keypad code lock and its bind
`default_nettype none
`include "assert_macros.svh"
module kmcl_checker
  import kmcl_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] status_o,
  input wire logic [2:0] mode_o,
  input wire logic [2:0] stars_shown_o
);
  `ASSERT_IMP(a_one_at_a_time, clk_i, rst_ni, out_valid_o |-> in_stall_o, "input during output")
  `ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "output dropped")
  `ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o |-> status_o <= ST_NO_CHANNEL, "bad status")
  `ASSERT_IMP(a_stars_mode, clk_i, rst_ni, (mode_o == MODE_SET_COUNT || mode_o == MODE_SELECT) |-> stars_shown_o == 3'd0, "stars")
endmodule
bind keypad_multichannel_code_lock_unit kmcl_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .mode_o, .stars_shown_o
);
`default_nettype wire
